### rtl/core/ppat_pkg.sv
// Shared constants and types of the ping-pong acquire and transmit sequencer.
`timescale 1ns / 1ps

package ppat_pkg;

   localparam int SAMPLES_PER_BUFFER = 16;
   localparam int SAMPLE_BITS        = 32;
   localparam int STORE_DEPTH        = 2 * SAMPLES_PER_BUFFER;
   localparam int STORE_ADDR_BITS    = $clog2(STORE_DEPTH);
   localparam int COUNT_BITS         = $clog2(SAMPLES_PER_BUFFER + 1);
   localparam int QUEUE_DEPTH        = 4;

   localparam logic [1:0] OP_START  = 2'd0;
   localparam logic [1:0] OP_SAMPLE = 2'd1;
   localparam logic [1:0] OP_SLOT   = 2'd2;

   localparam logic [2:0] KIND_READ   = 3'd0;
   localparam logic [2:0] KIND_HEADER = 3'd1;
   localparam logic [2:0] KIND_WORD   = 3'd2;
   localparam logic [2:0] KIND_END    = 3'd3;
   localparam logic [2:0] KIND_STOP   = 3'd4;
   localparam logic [2:0] KIND_DONE   = 3'd5;
   localparam logic [2:0] KIND_DROP   = 3'd6;

   typedef struct packed {
      logic [2:0]  kind;
      logic [31:0] word_out;
      logic        buffer_id;
      logic        last_of_run;
   } result_type;

   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } queue_push_type;

endpackage

### rtl/core/ping_pong_acquire_transmit.sv
// Top level of the ping-pong acquire and transmit sequencer.
//
//   channel   ports                               direction   handshake
//   request   req_op, req_sample_word             in          req_valid / req_stall
//   response  rsp_kind, rsp_word_out,             out         rsp_valid / rsp_stall
//             rsp_buffer_id, rsp_last_of_run
//   csr       csr_write_data (total_buffers)      in          csr_write_enable
//
// One request beat is taken every cycle while req_stall is low; sequencing state
// updates in the cycle of acceptance and the sample RAM is read or written in that
// same cycle. A response beat passes through the s1_ff pending register and the
// result queue before it can be taken; the queue releases one beat per cycle
// while rsp_stall is low. A request that causes two beats fills the queue faster
// than it drains, so under a long run of such requests req_stall holds acceptance.
// Reset is synchronous; the sample RAM is not cleared and needs no sweep.
// A stalled response side holds requests once the result queue is nearly full.
`timescale 1ns / 1ps

module ping_pong_acquire_transmit import ppat_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_op,
   input  logic [31:0] req_sample_word,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_kind,
   output logic [31:0] rsp_word_out,
   output logic        rsp_buffer_id,
   output logic        rsp_last_of_run,
   input  logic        csr_write_enable,
   input  logic [15:0] csr_write_data
);

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_FILL,
      PH_OVERLAP,
      PH_FINAL,
      PH_CLOSING
   } phase_type;

   typedef struct packed {
      logic [1:0] count;
      logic [2:0] kind0;
      logic       buf0;
      logic       word_first;
      logic [2:0] kind1;
      logic       buf1;
   } pending_type;

   phase_type               phase_ff, phase_in;
   logic                    sel_ff, sel_in;
   logic [COUNT_BITS-1:0]   fill_ff, fill_in;
   logic [COUNT_BITS-1:0]   send_ff, send_in;
   logic [15:0]             done_ff, done_in;
   logic [15:0]             total_ff;
   logic                    s1_valid_ff, s1_valid_in;
   pending_type             s1_ff, s1_in;

   logic                       req_accept;
   logic                       queue_room;
   logic                       s1_move;
   logic [COUNT_BITS-1:0]      fill_next;
   logic [15:0]                done_inc;
   logic                       mem_we, mem_re;
   logic                       read_buf;
   logic [STORE_ADDR_BITS-1:0] mem_waddr, mem_raddr;
   logic [SAMPLE_BITS-1:0]     mem_rdata;
   queue_push_type             push;
   result_type                 head;

   assign s1_move    = s1_valid_ff && queue_room;
   assign req_stall  = s1_valid_ff && !queue_room;
   assign req_accept = req_valid && !req_stall;

   assign done_inc  = (done_ff != 16'hFFFF) ? done_ff + 16'd1 : done_ff;
   assign mem_waddr = sel_ff ? STORE_ADDR_BITS'(SAMPLES_PER_BUFFER) + STORE_ADDR_BITS'(fill_ff)
                             : STORE_ADDR_BITS'(fill_ff);
   assign mem_raddr = read_buf ? STORE_ADDR_BITS'(SAMPLES_PER_BUFFER) + STORE_ADDR_BITS'(send_ff)
                               : STORE_ADDR_BITS'(send_ff);

   always_comb begin
      phase_in  = phase_ff;
      sel_in    = sel_ff;
      fill_in   = fill_ff;
      send_in   = send_ff;
      done_in   = done_ff;
      s1_in     = '0;
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      read_buf  = sel_ff;
      fill_next = fill_ff;
      if (req_accept) begin
         unique case (req_op)
            OP_START: begin
               if (phase_ff == PH_IDLE) begin
                  sel_in      = 1'b0;
                  fill_in     = '0;
                  send_in     = '0;
                  done_in     = '0;
                  phase_in    = PH_FILL;
                  s1_in.count = 2'd1;
                  s1_in.kind0 = KIND_READ;
               end
            end
            OP_SAMPLE: begin
               if (phase_ff == PH_FILL) begin
                  if (fill_ff < COUNT_BITS'(SAMPLES_PER_BUFFER)) begin
                     mem_we    = 1'b1;
                     fill_next = fill_ff + COUNT_BITS'(1);
                  end
                  fill_in = fill_next;
                  if (fill_next >= COUNT_BITS'(SAMPLES_PER_BUFFER)) begin
                     done_in = done_inc;
                     send_in = '0;
                     if (done_inc >= total_ff) begin
                        s1_in.count = 2'd2;
                        s1_in.kind0 = KIND_STOP;
                        s1_in.buf0  = sel_ff;
                        s1_in.kind1 = KIND_HEADER;
                        s1_in.buf1  = sel_ff;
                        phase_in    = PH_FINAL;
                     end else begin
                        s1_in.count = 2'd1;
                        s1_in.kind0 = KIND_HEADER;
                        s1_in.buf0  = sel_ff;
                        sel_in      = !sel_ff;
                        fill_in     = '0;
                        phase_in    = PH_OVERLAP;
                     end
                  end
               end else if (phase_ff == PH_OVERLAP) begin
                  if (fill_ff < COUNT_BITS'(SAMPLES_PER_BUFFER)) begin
                     mem_we  = 1'b1;
                     fill_in = fill_ff + COUNT_BITS'(1);
                  end else begin
                     s1_in.count = 2'd1;
                     s1_in.kind0 = KIND_DROP;
                     s1_in.buf0  = sel_ff;
                  end
               end
            end
            OP_SLOT: begin
               if (phase_ff == PH_OVERLAP) begin
                  read_buf         = !sel_ff;
                  mem_re           = 1'b1;
                  send_in          = send_ff + COUNT_BITS'(1);
                  s1_in.count      = 2'd1;
                  s1_in.kind0      = KIND_WORD;
                  s1_in.buf0       = !sel_ff;
                  s1_in.word_first = 1'b1;
                  if (send_in >= COUNT_BITS'(SAMPLES_PER_BUFFER)) begin
                     s1_in.count = 2'd2;
                     s1_in.kind1 = KIND_END;
                     s1_in.buf1  = !sel_ff;
                     phase_in    = PH_FILL;
                  end
               end else if (phase_ff == PH_FINAL) begin
                  mem_re           = 1'b1;
                  send_in          = send_ff + COUNT_BITS'(1);
                  s1_in.count      = 2'd1;
                  s1_in.kind0      = KIND_WORD;
                  s1_in.buf0       = sel_ff;
                  s1_in.word_first = 1'b1;
                  if (send_in >= COUNT_BITS'(SAMPLES_PER_BUFFER)) begin
                     phase_in = PH_CLOSING;
                  end
               end else if (phase_ff == PH_CLOSING) begin
                  s1_in.count = 2'd2;
                  s1_in.kind0 = KIND_END;
                  s1_in.buf0  = sel_ff;
                  s1_in.kind1 = KIND_DONE;
                  phase_in    = PH_IDLE;
               end
            end
            default: begin
            end
         endcase
      end
      s1_valid_in = req_accept ? (s1_in.count != 2'd0) : (s1_valid_ff && !queue_room);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         sel_ff      <= 1'b0;
         fill_ff     <= '0;
         send_ff     <= '0;
         done_ff     <= '0;
         total_ff    <= 16'd1;
         s1_valid_ff <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         sel_ff      <= sel_in;
         fill_ff     <= fill_in;
         send_ff     <= send_in;
         done_ff     <= done_in;
         s1_valid_ff <= s1_valid_in;
         if (csr_write_enable) begin
            total_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_ff <= s1_in;
      end
   end

   ppat_store #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock         (clock),
      .write_enable  (mem_we),
      .write_address (mem_waddr),
      .write_data    (SAMPLE_BITS'(req_sample_word)),
      .read_enable   (mem_re),
      .read_address  (mem_raddr),
      .read_data     (mem_rdata)
   );

   always_comb begin
      push.count              = s1_move ? s1_ff.count : 2'd0;
      push.first.kind         = s1_ff.kind0;
      push.first.word_out     = s1_ff.word_first ? 32'(mem_rdata) : 32'd0;
      push.first.buffer_id    = s1_ff.buf0;
      push.first.last_of_run  = (s1_ff.count == 2'd1);
      push.second.kind        = s1_ff.kind1;
      push.second.word_out    = 32'd0;
      push.second.buffer_id   = s1_ff.buf1;
      push.second.last_of_run = 1'b1;
   end

   ppat_result_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (queue_room),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .head      (head)
   );

   assign rsp_kind        = head.kind;
   assign rsp_word_out    = head.word_out;
   assign rsp_buffer_id   = head.buffer_id;
   assign rsp_last_of_run = head.last_of_run;

endmodule

### rtl/core/ppat_store.sv
// Simple dual-port synchronous RAM with a registered read port.
`timescale 1ns / 1ps

module ppat_store #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     write_enable,
   input  logic [$clog2(DEPTH)-1:0] write_address,
   input  logic [WIDTH-1:0]         write_data,
   input  logic                     read_enable,
   input  logic [$clog2(DEPTH)-1:0] read_address,
   output logic [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem[write_address] <= write_data;
      end
      if (read_enable) begin
         read_data_ff <= mem[read_address];
      end
   end

   assign read_data = read_data_ff;

endmodule

### rtl/core/ppat_result_queue.sv
// Small result queue that takes up to two beats per cycle and releases one while out_stall is low.
`timescale 1ns / 1ps

module ppat_result_queue import ppat_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  queue_push_type push,
   output logic           room,
   output logic           out_valid,
   input  logic           out_stall,
   output result_type     head
);

   localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   result_type            entries_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic                  pop;

   assign out_valid = (count_ff != '0);
   assign pop       = out_valid && !out_stall;
   assign room      = (count_ff <= CNT_BITS'(QUEUE_DEPTH - 2));
   assign head      = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_BITS'(push.count);
      rd_ptr_in = rd_ptr_ff + PTR_BITS'(pop);
      count_in  = count_ff + CNT_BITS'(push.count) - CNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entries_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entries_ff[wr_ptr_ff + PTR_BITS'(1)] <= push.second;
      end
   end

endmodule

### dv/tb.sv
// Self-checking testbench for the ping-pong acquire and transmit sequencer.
`timescale 1ns / 1ps

module tb;
   import ppat_pkg::*;

   localparam logic [1:0] OP_UNUSED  = 2'd3;
   localparam int LIMIT_CYCLES = 600000;
   localparam int DRAIN_CYCLES = 8;

   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_FILL,
      SEQ_OVERLAP,
      SEQ_FINAL,
      SEQ_CLOSING
   } seq_phase_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_op = OP_UNUSED;
   logic [31:0] req_sample_word = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_kind;
   logic [31:0] rsp_word_out;
   logic        rsp_buffer_id;
   logic        rsp_last_of_run;
   logic        csr_write_enable = 1'b0;
   logic [15:0] csr_write_data = '0;

   // Shadow state of the sequencer.
   logic [31:0]   word_store [0:STORE_DEPTH-1];
   logic          fill_sel = 1'b0;
   int            fill_cnt = 0;
   int            send_cnt = 0;
   logic [15:0]   bufs_done = '0;
   logic [15:0]   total_bufs = 16'd1;
   seq_phase_type seq_phase = SEQ_IDLE;

   result_type  pending_results [$];
   result_type  got;
   result_type  want;

   int  error_count = 0;
   int  beats_sent = 0;
   int  beats_checked = 0;
   int  drops_seen = 0;
   int  runs_closed = 0;
   int  cycle_count = 0;
   int  hold_left = 0;
   int  stall_left = 0;
   bit  req_gaps_on = 1'b1;
   bit  rsp_gaps_on = 1'b1;

   ping_pong_acquire_transmit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_op           (req_op),
      .req_sample_word  (req_sample_word),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_word_out     (rsp_word_out),
      .rsp_buffer_id    (rsp_buffer_id),
      .rsp_last_of_run  (rsp_last_of_run),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [31:0] rand_word();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 32'h0000_0000;
      if (r == 1) return 32'hFFFF_FFFF;
      return $urandom;
   endfunction

   function automatic result_type make_result(logic [2:0] kind, logic [31:0] word,
                                              logic side);
      result_type r;
      r.kind        = kind;
      r.word_out    = word;
      r.buffer_id   = side;
      r.last_of_run = 1'b0;
      return r;
   endfunction

   function automatic void store_sample(logic [31:0] word);
      word_store[int'(fill_sel) * SAMPLES_PER_BUFFER + fill_cnt] = word;
      fill_cnt++;
   endfunction

   function automatic logic [31:0] drain_word(logic side);
      logic [31:0] w;
      w = word_store[int'(side) * SAMPLES_PER_BUFFER + send_cnt];
      send_cnt++;
      return w;
   endfunction

   // Advances the shadow sequencer by one accepted beat and queues its results.
   task automatic advance_sequencer(input logic [1:0] op, input logic [31:0] word);
      result_type res [2];
      int n;
      logic side;
      n = 0;
      case (op)
         OP_START: begin
            if (seq_phase == SEQ_IDLE) begin
               fill_sel  = 1'b0;
               fill_cnt  = 0;
               send_cnt  = 0;
               bufs_done = '0;
               seq_phase = SEQ_FILL;
               res[0] = make_result(KIND_READ, '0, 1'b0);
               n = 1;
            end
         end
         OP_SAMPLE: begin
            if (seq_phase == SEQ_FILL) begin
               if (fill_cnt < SAMPLES_PER_BUFFER) store_sample(word);
               if (fill_cnt >= SAMPLES_PER_BUFFER) begin
                  if (bufs_done != 16'hFFFF) bufs_done++;
                  send_cnt = 0;
                  if (bufs_done >= total_bufs) begin
                     res[0] = make_result(KIND_STOP, '0, fill_sel);
                     res[1] = make_result(KIND_HEADER, '0, fill_sel);
                     n = 2;
                     seq_phase = SEQ_FINAL;
                  end else begin
                     res[0] = make_result(KIND_HEADER, '0, fill_sel);
                     n = 1;
                     fill_sel  = ~fill_sel;
                     fill_cnt  = 0;
                     seq_phase = SEQ_OVERLAP;
                  end
               end
            end else if (seq_phase == SEQ_OVERLAP) begin
               if (fill_cnt < SAMPLES_PER_BUFFER) begin
                  store_sample(word);
               end else begin
                  res[0] = make_result(KIND_DROP, '0, fill_sel);
                  n = 1;
               end
            end
         end
         OP_SLOT: begin
            if (seq_phase == SEQ_OVERLAP) begin
               side = ~fill_sel;
               res[0] = make_result(KIND_WORD, drain_word(side), side);
               n = 1;
               if (send_cnt >= SAMPLES_PER_BUFFER) begin
                  res[1] = make_result(KIND_END, '0, side);
                  n = 2;
                  seq_phase = SEQ_FILL;
               end
            end else if (seq_phase == SEQ_FINAL) begin
               res[0] = make_result(KIND_WORD, drain_word(fill_sel), fill_sel);
               n = 1;
               if (send_cnt >= SAMPLES_PER_BUFFER) seq_phase = SEQ_CLOSING;
            end else if (seq_phase == SEQ_CLOSING) begin
               res[0] = make_result(KIND_END, '0, fill_sel);
               res[1] = make_result(KIND_DONE, '0, 1'b0);
               n = 2;
               seq_phase = SEQ_IDLE;
            end
         end
         default: ;
      endcase
      if (n > 0) res[n-1].last_of_run = 1'b1;
      for (int i = 0; i < n; i++) pending_results.push_back(res[i]);
   endtask

   task automatic report_error(input string what, input result_type exp_r,
                               input result_type act_r);
      error_count++;
      if (error_count <= 10) begin
         $display("%0s: expected kind %0d word %h buf %0d last %0d",
                  what, exp_r.kind, exp_r.word_out, exp_r.buffer_id, exp_r.last_of_run);
         $display("   got kind %0d word %h buf %0d last %0d",
                  act_r.kind, act_r.word_out, act_r.buffer_id, act_r.last_of_run);
      end
   endtask

   task automatic send_beat(input logic [1:0] op, input logic [31:0] word);
      int gap;
      gap = req_gaps_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_op          <= op;
      req_sample_word <= word;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      advance_sequencer(op, word);
      beats_sent++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_total(input logic [15:0] value);
      wait_drained();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      total_bufs = value;
   endtask

   function automatic logic [1:0] pick_op();
      int r;
      r = $urandom_range(0, 99);
      if (r < 6) return OP_UNUSED;
      if (r < 10) return OP_START;
      case (seq_phase)
         SEQ_IDLE:    return (r < 20) ? OP_SAMPLE : (r < 30) ? OP_SLOT : OP_START;
         SEQ_FILL:    return (r < 85) ? OP_SAMPLE : OP_SLOT;
         SEQ_OVERLAP: return (r < 55) ? OP_SAMPLE : OP_SLOT;
         default:     return (r < 85) ? OP_SLOT : OP_SAMPLE;
      endcase
   endfunction

   task automatic run_random(input int budget);
      int sent;
      sent = 0;
      while ((sent < budget || seq_phase != SEQ_IDLE) && sent < budget + 600) begin
         send_beat(pick_op(), rand_word());
         sent++;
      end
   endtask

   task automatic test_directed_run();
      logic [31:0] w;
      write_total(16'd2);
      send_beat(OP_UNUSED, 32'hFFFF_FFFF);
      send_beat(OP_SLOT, '0);
      send_beat(OP_SAMPLE, 32'h1234_5678);
      send_beat(OP_START, '0);
      send_beat(OP_START, '0);
      send_beat(OP_SLOT, '0);
      send_beat(OP_UNUSED, '0);
      for (int i = 0; i < 2 * SAMPLES_PER_BUFFER; i++) begin
         case (i % 4)
            0:       w = 32'h0000_0000;
            1:       w = 32'hFFFF_FFFF;
            2:       w = 32'hAAAA_AAAA;
            default: w = 32'h5555_5555;
         endcase
         send_beat(OP_SAMPLE, (i < 4) ? w : rand_word());
      end
      send_beat(OP_SAMPLE, 32'hCAFE_F00D);
      repeat (SAMPLES_PER_BUFFER) send_beat(OP_SLOT, '0);
      send_beat(OP_SAMPLE, 32'h0BAD_0BAD);
      send_beat(OP_SAMPLE, 32'h7777_7777);
      send_beat(OP_START, '0);
      repeat (SAMPLES_PER_BUFFER) send_beat(OP_SLOT, '0);
      send_beat(OP_SAMPLE, 32'h8000_0001);
      send_beat(OP_SLOT, '0);
   endtask

   task automatic test_total_zero();
      write_total(16'd0);
      send_beat(OP_START, '0);
      run_random(20);
   endtask

   task automatic test_random_runs();
      for (int k = 0; k < 2; k++) begin
         req_gaps_on = (k != 0);
         rsp_gaps_on = (k != 0);
         write_total(16'($urandom_range(1, 2)));
         run_random(20);
      end
      req_gaps_on = 1'b1;
      rsp_gaps_on = 1'b1;
   endtask

   task automatic test_max_total();
      write_total(16'hFFFF);
      send_beat(OP_START, '0);
      while (bufs_done < 16'd2) send_beat(pick_op(), rand_word());
      write_total(16'd1);
      run_random(10);
   endtask

   task automatic test_backpressure();
      write_total(16'd2);
      req_gaps_on = 1'b0;
      hold_left = 300;
      send_beat(OP_START, '0);
      run_random(60);
      wait_drained();
      req_gaps_on = 1'b1;
      write_total(16'd1);
      run_random(30);
   endtask

   // Response side: check each accepted beat, then choose the next stall.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         got.kind        = rsp_kind;
         got.word_out    = rsp_word_out;
         got.buffer_id   = rsp_buffer_id;
         got.last_of_run = rsp_last_of_run;
         beats_checked++;
         if (got.kind == KIND_DROP) drops_seen++;
         if (got.kind == KIND_DONE) runs_closed++;
         if (pending_results.size() == 0) begin
            report_error("unexpected beat", '0, got);
         end else begin
            want = pending_results.pop_front();
            if (got.kind !== want.kind || got.word_out !== want.word_out ||
                got.buffer_id !== want.buffer_id || got.last_of_run !== want.last_of_run)
               report_error("mismatch", want, got);
         end
      end
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         stall_left = (rsp_gaps_on && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
         rsp_stall <= (stall_left > 0);
         if (stall_left > 0) stall_left--;
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("ping_pong_acquire_transmit regression: fail");
         $finish;
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_directed_run();
      test_total_zero();
      test_random_runs();
      test_max_total();
      test_backpressure();
      wait_drained();
      repeat (20) @(posedge clock);
      if (pending_results.size() != 0)
         report_error("missing beat", pending_results[0], '0);
      error_count += (pending_results.size() > 1) ? pending_results.size() - 1 : 0;
      $display("sent %0d request beats, checked %0d response beats in %0d cycles",
               beats_sent, beats_checked, cycle_count);
      $display("closed %0d acquisition runs, saw %0d dropped samples, %0d errors",
               runs_closed, drops_seen, error_count);
      if (error_count == 0)
         $display("ping_pong_acquire_transmit regression: pass");
      else
         $display("ping_pong_acquire_transmit regression: fail");
      $finish;
   end

endmodule
